// ===== design/sha1_pkg.sv =====
// Shared types and constants for the SHA-1 hash engine.
package sha1_pkg;

   typedef logic [31:0] word_type;
   typedef logic [6:0]  round_type;
   typedef logic [5:0]  pos_type;
   typedef logic [60:0] count_type;

   localparam int unsigned NUM_HASH_WORDS  = 5;
   localparam int unsigned NUM_BLOCK_WORDS = 16;

   localparam word_type H_INIT [0:NUM_HASH_WORDS-1] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
   };

   localparam word_type K_CH  = 32'h5a827999;
   localparam word_type K_PAR = 32'h6ed9eba1;
   localparam word_type K_MAJ = 32'h8f1bbcdc;
   localparam word_type K_XOR = 32'hca62c1d6;

   localparam round_type ROUND_CH_END  = 7'd20;
   localparam round_type ROUND_PAR_END = 7'd40;
   localparam round_type ROUND_MAJ_END = 7'd60;
   localparam round_type ROUND_LAST    = 7'd79;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam pos_type    POS_LEN  = 6'd56;
   localparam pos_type    POS_LAST = 6'd63;

   localparam logic [2:0] WORD_IDX_LAST = 3'd4;

endpackage

// ===== design/sha1_hash_engine_core.sv =====
// SHA-1 hash engine: byte stream in, five digest words out, one round per cycle.
// A byte that does not complete a block is taken and the engine stays ready; a byte
// that completes a block holds off the next item through 80 rounds on one shared
// round unit and the chaining add. On a last item the block feeds 64 - pos (or
// 128 - pos) padding bytes, one per cycle, compresses each padded block, then
// offers five digest words. Reset loads the initial chaining value.
module sha1_hash_engine_core
   import sha1_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] carries_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PAD   = 3'd1;
   localparam logic [2:0] ST_ROUND = 3'd2;
   localparam logic [2:0] ST_ADD   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0] state_ff, state_in;
   pos_type    pos_ff, pos_in;
   count_type  count_ff, count_in;
   round_type  rnd_ff, rnd_in;
   logic [2:0] idx_ff, idx_in;
   logic       pad_ff, pad_in;
   logic       mark_ff, mark_in;
   logic       lenblk_ff, lenblk_in;
   logic       fin_ff, fin_in;

   word_type   h_ff [0:NUM_HASH_WORDS-1];
   word_type   h_in [0:NUM_HASH_WORDS-1];
   word_type   v_ff [0:NUM_HASH_WORDS-1];
   word_type   v_in [0:NUM_HASH_WORDS-1];
   word_type   w_ff [0:NUM_BLOCK_WORDS-1];
   word_type   w_in [0:NUM_BLOCK_WORDS-1];
   word_type   w_shb [0:NUM_BLOCK_WORDS-1];

   logic [7:0]  byte_sel;
   logic [7:0]  pad_byte;
   logic        len_byte;
   logic [63:0] bit_len;
   word_type    f_val;
   word_type    k_val;
   word_type    w_new;
   word_type    t_sum;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = h_ff[idx_ff];
   assign rsp_tuser  = idx_ff;
   assign rsp_tlast  = (idx_ff == WORD_IDX_LAST);

   assign bit_len  = {count_ff, 3'b000};
   assign len_byte = mark_ff && lenblk_ff && (pos_ff >= POS_LEN);

   always_comb begin
      if (!mark_ff) begin
         pad_byte = PAD_MARK;
      end else if (len_byte) begin
         pad_byte = bit_len[(7 - pos_ff[2:0]) * 8 +: 8];
      end else begin
         pad_byte = 8'h00;
      end
      byte_sel = (state_ff == ST_PAD) ? pad_byte : req_tdata;
   end

   // shift the block left by one byte
   always_comb begin
      for (int i = 0; i < NUM_BLOCK_WORDS - 1; i++) begin
         w_shb[i] = {w_ff[i][23:0], w_ff[i+1][31:24]};
      end
      w_shb[NUM_BLOCK_WORDS-1] = {w_ff[NUM_BLOCK_WORDS-1][23:0], byte_sel};
   end

   // shared round unit
   always_comb begin
      if (rnd_ff < ROUND_CH_END) begin
         f_val = (v_ff[1] & v_ff[2]) | (~v_ff[1] & v_ff[3]);
         k_val = K_CH;
      end else if (rnd_ff < ROUND_PAR_END) begin
         f_val = v_ff[1] ^ v_ff[2] ^ v_ff[3];
         k_val = K_PAR;
      end else if (rnd_ff < ROUND_MAJ_END) begin
         f_val = (v_ff[1] & v_ff[2]) | (v_ff[1] & v_ff[3]) | (v_ff[2] & v_ff[3]);
         k_val = K_MAJ;
      end else begin
         f_val = v_ff[1] ^ v_ff[2] ^ v_ff[3];
         k_val = K_XOR;
      end
      w_new = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      w_new = {w_new[30:0], w_new[31]};
      t_sum = {v_ff[0][26:0], v_ff[0][31:27]} + f_val + v_ff[4] + k_val + w_ff[0];
   end

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      rnd_in    = rnd_ff;
      idx_in    = idx_ff;
      pad_in    = pad_ff;
      mark_in   = mark_ff;
      lenblk_in = lenblk_ff;
      fin_in    = fin_ff;
      h_in      = h_ff;
      v_in      = v_ff;
      w_in      = w_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser) begin
                  w_in     = w_shb;
                  pos_in   = pos_ff + 6'd1;
                  count_in = count_ff + 61'd1;
               end
               if (req_tlast) begin
                  pad_in  = 1'b1;
                  mark_in = 1'b0;
               end
               if (req_tuser && (pos_ff == POS_LAST)) begin
                  state_in = ST_ROUND;
                  rnd_in   = '0;
                  v_in     = h_ff;
               end else if (req_tlast) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            w_in    = w_shb;
            pos_in  = pos_ff + 6'd1;
            mark_in = 1'b1;
            if (pos_ff == POS_LAST) begin
               lenblk_in = 1'b1;
            end else if (!mark_ff) begin
               lenblk_in = (pos_ff < POS_LEN);
            end
            if (pos_ff == POS_LAST) begin
               fin_in   = len_byte;
               state_in = ST_ROUND;
               rnd_in   = '0;
               v_in     = h_ff;
            end
         end
         ST_ROUND: begin
            for (int i = 0; i < NUM_BLOCK_WORDS - 1; i++) begin
               w_in[i] = w_ff[i+1];
            end
            w_in[NUM_BLOCK_WORDS-1] = w_new;
            v_in[0] = t_sum;
            v_in[1] = v_ff[0];
            v_in[2] = {v_ff[1][1:0], v_ff[1][31:2]};
            v_in[3] = v_ff[2];
            v_in[4] = v_ff[3];
            rnd_in  = rnd_ff + 7'd1;
            if (rnd_ff == ROUND_LAST) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < NUM_HASH_WORDS; i++) begin
               h_in[i] = h_ff[i] + v_ff[i];
            end
            idx_in = '0;
            if (fin_ff) begin
               state_in = ST_OUT;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == WORD_IDX_LAST) begin
                  h_in      = H_INIT;
                  count_in  = '0;
                  pos_in    = '0;
                  pad_in    = 1'b0;
                  mark_in   = 1'b0;
                  lenblk_in = 1'b0;
                  fin_in    = 1'b0;
                  idx_in    = '0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pos_ff    <= '0;
         count_ff  <= '0;
         rnd_ff    <= '0;
         idx_ff    <= '0;
         pad_ff    <= 1'b0;
         mark_ff   <= 1'b0;
         lenblk_ff <= 1'b0;
         fin_ff    <= 1'b0;
         h_ff      <= H_INIT;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         count_ff  <= count_in;
         rnd_ff    <= rnd_in;
         idx_ff    <= idx_in;
         pad_ff    <= pad_in;
         mark_ff   <= mark_in;
         lenblk_ff <= lenblk_in;
         fin_ff    <= fin_in;
         h_ff      <= h_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      w_ff <= w_in;
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while digest pending");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser == WORD_IDX_LAST))
      else $error("last digest word at wrong index");

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (rnd_ff <= ROUND_LAST))
      else $error("round counter overrun");

   a_block_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (pos_ff == '0))
      else $error("compression on partial block");

endmodule

// ===== verif/sha1_digest_checker.sv =====
// Checker for the SHA-1 engine: tracks message items and compares digest words.
module sha1_digest_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] carries_byte
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [31:0] digest_word
   input  logic [2:0]  rsp_tuser,   // [2:0] word_index
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending,
   output int          words_checked
);

   localparam int         DIGEST_WORDS    = 5;
   localparam logic [2:0] LAST_WORD_INDEX = 3'(DIGEST_WORDS - 1);
   localparam logic [7:0] PAD_BYTE        = 8'h80;
   localparam int         LENGTH_POS      = 56;
   localparam int         BLOCK_END_POS   = 63;

   localparam logic [31:0] IV [DIGEST_WORDS] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
   };
   localparam logic [31:0] ROUND_K [4] = '{
      32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
   };

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   logic [31:0]     chain [DIGEST_WORDS];
   logic [31:0]     msg_block [16];
   logic [60:0]     msg_bytes;
   digest_word_type expected_digest_words [$];
   digest_word_type oldest;
   int              mismatches;
   int              matched;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function void compress_block();
      logic [31:0] a, b, c, d, e, f, w, k, t_sum;
      int          t;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (t = 0; t < 80; t++) begin
         if (t >= 16) begin
            w = rotl(msg_block[(t - 3) & 15] ^ msg_block[(t - 8) & 15] ^
                     msg_block[(t - 14) & 15] ^ msg_block[t & 15], 1);
            msg_block[t & 15] = w;
         end else begin
            w = msg_block[t];
         end
         if (t < 20) begin
            f = (b & c) | (~b & d);
         end else if (t < 40 || t >= 60) begin
            f = b ^ c ^ d;
         end else begin
            f = (b & c) | (b & d) | (c & d);
         end
         k = ROUND_K[t / 20];
         t_sum = rotl(a, 5) + f + e + k + w;
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = t_sum;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
   endfunction

   function void put_byte(input int pos, input logic [7:0] value);
      int wi;
      int sh;
      wi = pos >> 2;
      sh = (3 - (pos & 3)) * 8;
      if ((pos & 3) == 0) begin
         msg_block[wi] = 32'(value) << sh;
      end else begin
         msg_block[wi] |= 32'(value) << sh;
      end
   endfunction

   function void start_message();
      int j;
      for (j = 0; j < DIGEST_WORDS; j++) chain[j] = IV[j];
      msg_bytes = '0;
   endfunction

   function void queue_expected(input digest_word_type dw);
      expected_digest_words = {expected_digest_words, dw};
   endfunction

   function void absorb_item(input logic [7:0] data, input logic has_byte, input logic is_last);
      int              pos;
      int              wi;
      int              j;
      logic [63:0]     bit_len;
      digest_word_type dw;
      if (has_byte) begin
         pos = int'(msg_bytes[5:0]);
         put_byte(pos, data);
         msg_bytes = msg_bytes + 61'd1;
         if (pos == BLOCK_END_POS) compress_block();
      end
      if (!is_last) return;
      pos = int'(msg_bytes[5:0]);
      put_byte(pos, PAD_BYTE);
      for (wi = (pos >> 2) + 1; wi < 16; wi++) msg_block[wi] = '0;
      if (pos >= LENGTH_POS) begin
         compress_block();
         for (wi = 0; wi < 14; wi++) msg_block[wi] = '0;
      end
      bit_len = {msg_bytes, 3'b000};
      msg_block[14] = bit_len[63:32];
      msg_block[15] = bit_len[31:0];
      compress_block();
      for (j = 0; j < DIGEST_WORDS; j++) begin
         dw.word  = chain[j];
         dw.index = 3'(j);
         dw.last  = (3'(j) == LAST_WORD_INDEX);
         queue_expected(dw);
      end
      start_message();
   endfunction

   task report_mismatch(input string what);
      $display("mismatch: %s", what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start_message();
         expected_digest_words.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_digest_words.size() == 0) begin
               report_mismatch($sformatf("digest word %h with none expected", rsp_tdata));
            end else begin
               oldest = expected_digest_words.pop_front();
               if (rsp_tdata !== oldest.word)
                  report_mismatch($sformatf("digest_word %h, expected %h (index %0d)",
                                            rsp_tdata, oldest.word, oldest.index));
               if (rsp_tuser !== oldest.index)
                  report_mismatch($sformatf("word_index %0d, expected %0d",
                                            rsp_tuser, oldest.index));
               if (rsp_tlast !== oldest.last)
                  report_mismatch($sformatf("last_word %b, expected %b (index %0d)",
                                            rsp_tlast, oldest.last, oldest.index));
               matched++;
            end
         end
         if (req_tvalid && req_tready) absorb_item(req_tdata, req_tuser, req_tlast);
      end
      fail_count    <= mismatches;
      pending       <= expected_digest_words.size();
      words_checked <= matched;
   end

endmodule

// ===== verif/tb.sv =====
// Top of the SHA-1 engine testbench: clock, reset, message stimulus and verdict.
module tb;

   localparam int CLK_PERIOD     = 4;
   localparam int NUM_ITEMS      = 370;
   localparam int MIN_MESSAGES   = 14;
   localparam int DRAIN_CYCLES   = 400;
   localparam int TIMEOUT_CYCLES = 1000000;

   localparam int BOUNDARY_LEN [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   int          fail_count;
   int          pending;
   int          words_checked;

   int tx_idle_pct   = 15;
   int rx_idle_pct   = 70;
   int items_sent    = 0;
   int messages_sent = 0;

   sha1_hash_engine_core u_dut (.*);

   sha1_digest_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= rx_idle_pct);
   end

   task automatic send_item(input logic [7:0] data, input logic has_byte, input logic is_last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= has_byte;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (has_byte || is_last) items_sent++;
   endtask

   task automatic send_message(input int len, input bit last_alone);
      int i;
      for (i = 0; i < len; i++) begin
         if ($urandom_range(19) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
         send_item(8'($urandom_range(255)), 1'b1, (i == len - 1) && !last_alone);
      end
      if (len == 0 || last_alone) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
      messages_sent++;
   endtask

   initial begin : stimulus
      int sel;
      int len;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      req_tlast  <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty message, then "abc" with the last byte and last together
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hff, 1'b0, 1'b0);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      // extreme bytes, then last on an item without a byte, then three one-byte messages
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'hff, 1'b0, 1'b1);
      send_item(8'h80, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hff, 1'b1, 1'b1);
      messages_sent += 6;

      while (items_sent < NUM_ITEMS || messages_sent < MIN_MESSAGES) begin
         if (items_sent >= 2 * NUM_ITEMS / 3) begin
            tx_idle_pct = 0;
            rx_idle_pct <= 0;
         end else if (items_sent >= NUM_ITEMS / 3) begin
            tx_idle_pct = 70;
            rx_idle_pct <= 15;
         end
         sel = $urandom_range(9);
         if (sel < 7) begin
            len = $urandom_range(8);
         end else if (sel < 9) begin
            len = BOUNDARY_LEN[$urandom_range(9)];
         end else begin
            len = $urandom_range(130, 9);
         end
         send_message(len, (len == 0) || ($urandom_range(2) == 0));
      end
      req_tvalid <= 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d message items in %0d messages, %0d digest words compared",
               items_sent, messages_sent, words_checked);
      $display("lengths 0 to 130 bytes incl. padding edges, three sender/receiver idle mixes");
      if (fail_count == 0 && pending == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   initial begin
      #(CLK_PERIOD * TIMEOUT_CYCLES);
      $display("tb failed");
      $finish;
   end

endmodule

// ===== files.f =====
design/sha1_pkg.sv
design/sha1_hash_engine_core.sv
verif/sha1_digest_checker.sv
verif/tb.sv
